// File: sv/bifs_pkg.sv
// Shared constants, codes and controller/datapath interface types for the flow search unit.
`default_nettype none

package bifs_pkg;

   localparam int FLOW_BYTES       = 8;
   localparam int IDX_W            = 3;
   localparam int NUM_OCTET_TABLES = 4;
   localparam int OCTET_ROWS       = 256;
   localparam int PORT_ROWS        = 65536;
   localparam int TBL_W            = $clog2(NUM_OCTET_TABLES);
   localparam int OCT_ROW_W        = $clog2(OCTET_ROWS);
   localparam int PORT_ROW_W       = $clog2(PORT_ROWS);
   localparam int OCT_DEPTH        = NUM_OCTET_TABLES * OCTET_ROWS * FLOW_BYTES;
   localparam int PORT_DEPTH       = PORT_ROWS * FLOW_BYTES;
   localparam int OCT_ADDR_W       = $clog2(OCT_DEPTH);
   localparam int PORT_ADDR_W      = $clog2(PORT_DEPTH);

   localparam int BYTE_W   = 8;
   localparam int FLOW_W   = 7;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int USED_W   = 3;

   localparam logic [BYTE_W-1:0] ALL_ONES = 8'hFF;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_OCTET_1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_OCTET_2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_OCTET_3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_OCTET_4 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTETS_USED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_KEY    = 3'd5;

   // Function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_SCAN = 1'b1;

   // Table select code of the port table
   localparam logic [2:0] TBL_PORT = 3'd4;

   typedef struct packed {
      logic             capture;
      logic             load_wr;
      logic             oct_rd;
      logic [TBL_W-1:0] tbl;
      logic             port_rd;
      logic             emit;
   } bifs_cmd_type;

   typedef struct packed {
      logic [USED_W-1:0] used;
      logic              port_en;
      logic              emit_last;
   } bifs_stat_type;

endpackage

`default_nettype wire

// File: sv/bitmap_index_flow_search_unit.sv
// Top level of the bitmap-index flow search unit.
// An item is taken when start is high and busy is low. A load item writes one
// bitmap byte in the cycle after acceptance, with busy high. A scan item reads
// the selected octet rows (octets_used, at most 4) one per cycle from the
// single-read-port octet memory, then the port row if the port key is nonzero,
// and ANDs them; busy then stays high up to the last result, one result per
// cycle (at most eight, or one not-found result). Each result shows on the
// rsp_ ports for one cycle with rsp_strobe high, in the cycle after it is
// formed; the receiver cannot stall. Bitmap memories are not cleared at reset:
// read only bytes that were loaded. Write configuration only while busy is low.
`default_nettype none

module bitmap_index_flow_search_unit
   import bifs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_func,
   input  wire logic [2:0]           req_table_select,
   input  wire logic [15:0]          req_row,
   input  wire logic [IDX_W-1:0]     req_byte_index,
   input  wire logic [BYTE_W-1:0]    req_load_data,
   output logic                      rsp_strobe,
   output logic      [FLOW_W-1:0]    rsp_flow_number,
   output logic                      rsp_found,
   output logic                      rsp_last,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_write_data
);

   bifs_cmd_type  cmd;
   bifs_stat_type stat;

   bifs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .busy     (busy),
      .stat     (stat),
      .cmd      (cmd)
   );

   bifs_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_table_select (req_table_select),
      .req_row          (req_row),
      .req_byte_index   (req_byte_index),
      .req_load_data    (req_load_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_flow_number  (rsp_flow_number),
      .rsp_found        (rsp_found),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// File: sv/bifs_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module bifs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/bifs_ctrl.sv
// Controller state machine: sequences loads, table reads and result emission.
`default_nettype none

module bifs_ctrl
   import bifs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_func,
   output logic               busy,
   input  wire bifs_stat_type stat,
   output bifs_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_OCT,
      ST_PORT,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [USED_W-1:0] t_ff, t_in;

   always_comb begin
      state_in = state_ff;
      t_in     = t_ff;
      cmd      = '0;
      cmd.tbl  = t_ff[TBL_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               t_in        = '0;
               state_in    = (req_func == FUNC_SCAN) ? ST_OCT : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_OCT: begin
            // one octet row read per cycle; data is folded in the following cycle
            if (t_ff < stat.used) begin
               cmd.oct_rd = 1'b1;
               t_in       = t_ff + USED_W'(1);
            end else begin
               state_in = ST_PORT;
            end
         end
         ST_PORT: begin
            cmd.port_rd = stat.port_en;
            state_in    = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (stat.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         t_ff     <= '0;
      end else begin
         state_ff <= state_in;
         t_ff     <= t_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_rd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.oct_rd && cmd.port_rd))
      else $error("octet and port reads issued together");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      t_ff <= USED_W'(NUM_OCTET_TABLES))
      else $error("octet read count beyond table count");

   a_capture_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> busy)
      else $error("accepted item did not make the block busy");

   a_no_emit_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(cmd.oct_rd || cmd.port_rd || cmd.load_wr))
      else $error("emission overlaps memory access");

endmodule

`default_nettype wire

// File: sv/bifs_dpath.sv
// Datapath: configuration registers, bitmap memories, AND accumulator and flow encoder.
`default_nettype none

module bifs_dpath
   import bifs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bifs_cmd_type          cmd,
   output bifs_stat_type              stat,
   input  wire logic [2:0]            req_table_select,
   input  wire logic [15:0]           req_row,
   input  wire logic [IDX_W-1:0]      req_byte_index,
   input  wire logic [BYTE_W-1:0]     req_load_data,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_write_data,
   output logic                       rsp_strobe,
   output logic      [FLOW_W-1:0]     rsp_flow_number,
   output logic                       rsp_found,
   output logic                       rsp_last
);

   // configuration
   logic [OCT_ROW_W-1:0]  key_octet_ff [NUM_OCTET_TABLES];
   logic [USED_W-1:0]     octets_used_ff;
   logic [PORT_ROW_W-1:0] port_key_ff;

   // captured item
   logic [2:0]            sel_ff;
   logic [15:0]           row_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [BYTE_W-1:0]     data_ff;

   logic [BYTE_W-1:0]     acc_ff, acc_in;
   logic                  oct_pend_ff, port_pend_ff;
   logic                  rsp_strobe_ff;
   logic [FLOW_W-1:0]     rsp_flow_ff, flow_in;
   logic                  rsp_found_ff, rsp_last_ff;

   logic                  req_idx_ok, idx_ok;
   logic                  oct_we, port_we;
   logic [OCT_ADDR_W-1:0] oct_waddr, oct_raddr;
   logic [PORT_ADDR_W-1:0] port_waddr, port_raddr;
   logic [BYTE_W-1:0]     oct_rdata, port_rdata;
   logic [BYTE_W-1:0]     acc_fold;
   logic [IDX_W-1:0]      hi_bit;
   logic [BYTE_W-1:0]     acc_cleared;
   logic                  any_set, emit_last;

   assign req_idx_ok = (32'(req_byte_index) < FLOW_BYTES);
   assign idx_ok     = (32'(idx_ff) < FLOW_BYTES);

   // loads of octet rows above the table size or unknown tables are dropped
   assign oct_we  = cmd.load_wr && idx_ok && (32'(sel_ff) < NUM_OCTET_TABLES)
                    && (32'(row_ff) < OCTET_ROWS);
   assign port_we = cmd.load_wr && idx_ok && (sel_ff == TBL_PORT);

   assign oct_waddr  = {sel_ff[TBL_W-1:0], row_ff[OCT_ROW_W-1:0], idx_ff};
   assign port_waddr = {row_ff[PORT_ROW_W-1:0], idx_ff};
   assign oct_raddr  = {cmd.tbl, key_octet_ff[cmd.tbl], idx_ff};
   assign port_raddr = {port_key_ff, idx_ff};

   bifs_ram #(.WIDTH(BYTE_W), .DEPTH(OCT_DEPTH)) u_oct_ram (
      .clock   (clock),
      .wr_en   (oct_we),
      .wr_addr (oct_waddr),
      .wr_data (data_ff),
      .rd_en   (cmd.oct_rd),
      .rd_addr (oct_raddr),
      .rd_data (oct_rdata)
   );

   bifs_ram #(.WIDTH(BYTE_W), .DEPTH(PORT_DEPTH)) u_port_ram (
      .clock   (clock),
      .wr_en   (port_we),
      .wr_addr (port_waddr),
      .wr_data (data_ff),
      .rd_en   (cmd.port_rd),
      .rd_addr (port_raddr),
      .rd_data (port_rdata)
   );

   assign acc_fold = acc_ff & (oct_pend_ff ? oct_rdata : ALL_ONES)
                            & (port_pend_ff ? port_rdata : ALL_ONES);

   // highest set bit of the accumulator, bit 7 is the lowest flow number
   always_comb begin
      hi_bit = '0;
      for (int j = 0; j < BYTE_W; j++) begin
         if (acc_ff[j]) begin
            hi_bit = IDX_W'(j);
         end
      end
   end

   assign any_set     = |acc_ff;
   assign acc_cleared = acc_ff & ~(BYTE_W'(1) << hi_bit);
   assign emit_last   = !any_set || (acc_cleared == '0);
   assign flow_in     = FLOW_W'({idx_ff, 3'b000}) + FLOW_W'(4'd8 - {1'b0, hi_bit});

   always_comb begin
      acc_in = acc_fold;
      if (cmd.capture) begin
         acc_in = req_idx_ok ? ALL_ONES : '0;
      end else if (cmd.emit) begin
         acc_in = acc_cleared;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_OCTET_TABLES; k++) begin
            key_octet_ff[k] <= '0;
         end
         octets_used_ff <= '0;
         port_key_ff    <= '0;
         oct_pend_ff    <= 1'b0;
         port_pend_ff   <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_KEY_OCTET_1: key_octet_ff[0] <= csr_write_data[OCT_ROW_W-1:0];
               CSR_KEY_OCTET_2: key_octet_ff[1] <= csr_write_data[OCT_ROW_W-1:0];
               CSR_KEY_OCTET_3: key_octet_ff[2] <= csr_write_data[OCT_ROW_W-1:0];
               CSR_KEY_OCTET_4: key_octet_ff[3] <= csr_write_data[OCT_ROW_W-1:0];
               CSR_OCTETS_USED: octets_used_ff  <= csr_write_data[USED_W-1:0];
               CSR_PORT_KEY:    port_key_ff     <= csr_write_data[PORT_ROW_W-1:0];
               default: begin
               end
            endcase
         end
         oct_pend_ff   <= cmd.oct_rd;
         port_pend_ff  <= cmd.port_rd;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sel_ff  <= req_table_select;
         row_ff  <= req_row;
         idx_ff  <= req_byte_index;
         data_ff <= req_load_data;
      end
      acc_ff <= acc_in;
      if (cmd.emit) begin
         rsp_flow_ff  <= any_set ? flow_in : '0;
         rsp_found_ff <= any_set;
         rsp_last_ff  <= emit_last;
      end
   end

   assign stat.used      = (octets_used_ff > USED_W'(NUM_OCTET_TABLES))
                           ? USED_W'(NUM_OCTET_TABLES) : octets_used_ff;
   assign stat.port_en   = (port_key_ff != '0);
   assign stat.emit_last = emit_last;

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_flow_number = rsp_flow_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_last        = rsp_last_ff;

   a_notfound_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_found_ff) |-> rsp_last_ff)
      else $error("not-found result not marked last");

   a_emit_strobe: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && emit_last) |=> (rsp_strobe_ff && rsp_last_ff))
      else $error("final emission did not produce a last transfer");

   a_found_flow: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_found_ff) |-> (rsp_flow_ff != '0))
      else $error("found result carries flow zero");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the bitmap-index flow search unit.
`timescale 1ns / 1ps

module testbench
   import bifs_pkg::*;
();

   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [FLOW_W-1:0] flow_number;
      logic              found;
      logic              last;
   } flow_hit_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_func = FUNC_LOAD;
   logic [2:0]           req_table_select = '0;
   logic [15:0]          req_row = '0;
   logic [IDX_W-1:0]     req_byte_index = '0;
   logic [BYTE_W-1:0]    req_load_data = '0;
   logic                 rsp_strobe;
   logic [FLOW_W-1:0]    rsp_flow_number;
   logic                 rsp_found;
   logic                 rsp_last;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_KEY_OCTET_1;
   logic [CSR_W-1:0]     csr_write_data = '0;

   // shadow of the block: bitmap bytes written so far and the key registers
   logic [BYTE_W-1:0] octet_bitmap [int];
   logic [BYTE_W-1:0] port_shadow [int];
   logic [7:0]        key_octet [NUM_OCTET_TABLES];
   logic [USED_W-1:0] octets_used;
   logic [15:0]       port_key;

   flow_hit_type expected_flows [$];
   int        mismatch_count = 0;
   int        idle_cycles = 0;
   int        items_sent = 0;
   bit        idle_gaps = 1'b1;

   bitmap_index_flow_search_unit uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_table_select (req_table_select),
      .req_row          (req_row),
      .req_byte_index   (req_byte_index),
      .req_load_data    (req_load_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_flow_number  (rsp_flow_number),
      .rsp_found        (rsp_found),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic int octet_addr(int tbl, logic [7:0] row, logic [IDX_W-1:0] idx);
      return (tbl * OCTET_ROWS + int'(row)) * FLOW_BYTES + int'(idx);
   endfunction

   function automatic int port_addr(logic [15:0] row, logic [IDX_W-1:0] idx);
      return int'(row) * FLOW_BYTES + int'(idx);
   endfunction

   function automatic int octets_in_match();
      return (octets_used > 4) ? 4 : int'(octets_used);
   endfunction

   // AND of the selected rows at one byte position
   function automatic logic [BYTE_W-1:0] matched_flows(logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] acc;
      acc = ALL_ONES;
      for (int t = 0; t < octets_in_match(); t++)
         acc &= octet_bitmap[octet_addr(t, key_octet[t], idx)];
      if (port_key != 0)
         acc &= port_shadow[port_addr(port_key, idx)];
      return acc;
   endfunction

   task automatic queue_flow_hits(logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] hits;
      flow_hit_type      hit;
      hits = matched_flows(idx);
      if (hits == 0) begin
         hit = '{flow_number: '0, found: 1'b0, last: 1'b1};
         expected_flows.push_back(hit);
      end else begin
         for (int j = 7; j >= 0; j--) begin
            if (hits[j]) begin
               hit.flow_number = FLOW_W'(int'(idx) * 8 + 8 - j);
               hit.found = 1'b1;
               hit.last = ((hits & ((8'd1 << j) - 8'd1)) == 0);
               expected_flows.push_back(hit);
            end
         end
      end
   endtask

   task automatic apply_item(logic func, logic [2:0] sel, logic [15:0] row,
                             logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      if (func == FUNC_SCAN)
         queue_flow_hits(idx);
      else if (sel < TBL_PORT && row <= 16'h00FF)
         octet_bitmap[octet_addr(int'(sel), row[7:0], idx)] = data;
      else if (sel == TBL_PORT)
         port_shadow[port_addr(row, idx)] = data;
   endtask

   task automatic send_item(logic func, logic [2:0] sel, logic [15:0] row,
                            logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      int gap;
      gap = idle_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_func <= func;
      req_table_select <= sel;
      req_row <= row;
      req_byte_index <= idx;
      req_load_data <= data;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_item(func, sel, row, idx, data);
      items_sent++;
   endtask

   // bias toward set bits so that ANDs of several rows still hit
   function automatic logic [BYTE_W-1:0] dense_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2, 3: return BYTE_W'($urandom);
         default: return BYTE_W'($urandom | $urandom | $urandom);
      endcase
   endfunction

   // load any byte that the next scan at idx would read before it was written
   task automatic make_readable(logic [IDX_W-1:0] idx);
      int n;
      n = octets_in_match();
      for (int t = 0; t < n; t++)
         if (!octet_bitmap.exists(octet_addr(t, key_octet[t], idx)))
            send_item(FUNC_LOAD, 3'(t), {8'h00, key_octet[t]}, idx, dense_byte());
      if (port_key != 0 && !port_shadow.exists(port_addr(port_key, idx)))
         send_item(FUNC_LOAD, TBL_PORT, port_key, idx, dense_byte());
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      while (expected_flows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         CSR_KEY_OCTET_1: key_octet[0] = value[7:0];
         CSR_KEY_OCTET_2: key_octet[1] = value[7:0];
         CSR_KEY_OCTET_3: key_octet[2] = value[7:0];
         CSR_KEY_OCTET_4: key_octet[3] = value[7:0];
         CSR_OCTETS_USED: octets_used = value[USED_W-1:0];
         CSR_PORT_KEY:    port_key = value;
         default: ;
      endcase
   endtask

   task automatic set_keys(logic [7:0] k1, logic [7:0] k2, logic [7:0] k3, logic [7:0] k4,
                           logic [USED_W-1:0] used, logic [15:0] port);
      wait_quiet();
      write_reg(CSR_KEY_OCTET_1, {8'h00, k1});
      write_reg(CSR_KEY_OCTET_2, {8'h00, k2});
      write_reg(CSR_KEY_OCTET_3, {8'h00, k3});
      write_reg(CSR_KEY_OCTET_4, {8'h00, k4});
      write_reg(CSR_OCTETS_USED, {13'd0, used});
      write_reg(CSR_PORT_KEY, port);
      csr_write_enable <= 1'b0;
   endtask

   // reset keys: no rows take part, every flow of the byte matches
   task automatic test_open_match();
      send_item(FUNC_SCAN, 3'd0, 16'h0000, 3'd0, 8'h00);
      send_item(FUNC_SCAN, 3'd7, 16'hFFFF, 3'd7, 8'hFF);
   endtask

   task automatic test_corner_loads();
      logic [7:0] keys [4];
      keys = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
      set_keys(keys[0], keys[1], keys[2], keys[3], 3'd4, 16'hFFFF);
      // lowest flow only
      for (int t = 0; t < 4; t++)
         send_item(FUNC_LOAD, 3'(t), {8'h00, keys[t]}, 3'd0, 8'h80);
      send_item(FUNC_LOAD, TBL_PORT, 16'hFFFF, 3'd0, 8'h80);
      send_item(FUNC_SCAN, 3'd0, 16'h0000, 3'd0, 8'h00);
      // highest flow only
      for (int t = 0; t < 4; t++)
         send_item(FUNC_LOAD, 3'(t), {8'h00, keys[t]}, 3'd7, 8'hFF);
      send_item(FUNC_LOAD, TBL_PORT, 16'hFFFF, 3'd7, 8'h01);
      send_item(FUNC_SCAN, 3'd4, 16'h1234, 3'd7, 8'h55);
      // disjoint octet and port bits: nothing found
      for (int t = 0; t < 4; t++)
         send_item(FUNC_LOAD, 3'(t), {8'h00, keys[t]}, 3'd3, 8'hF0);
      send_item(FUNC_LOAD, TBL_PORT, 16'hFFFF, 3'd3, 8'h0F);
      send_item(FUNC_SCAN, 3'd0, 16'h0000, 3'd3, 8'h00);
      // octet row past 255 and undefined table codes must not write anything
      send_item(FUNC_LOAD, 3'd0, 16'h0100, 3'd0, 8'h00);
      send_item(FUNC_LOAD, 3'd5, 16'hFFFF, 3'd0, 8'h00);
      send_item(FUNC_LOAD, 3'd7, 16'hFFFF, 3'd0, 8'h00);
      send_item(FUNC_SCAN, 3'd0, 16'h0000, 3'd0, 8'h00);
   endtask

   task automatic test_saturated_octets();
      set_keys(8'h00, 8'hFF, 8'hA5, 8'h5A, 3'd7, 16'h0000);
      send_item(FUNC_SCAN, 3'd0, 16'h0000, 3'd7, 8'h00);
   endtask

   task automatic test_random_phases();
      logic [7:0]       k [4];
      logic [15:0]      port;
      logic [2:0]       sel;
      logic [15:0]      row;
      logic [IDX_W-1:0] idx;
      int               phase_end;
      int               t;
      for (int p = 0; p < 8; p++) begin
         for (int i = 0; i < 4; i++)
            k[i] = (p == 0) ? 8'h00 : (p == 7) ? 8'hFF : 8'($urandom_range(0, 255));
         if (p % 4 == 0)
            port = 16'h0000;
         else if (p == 2)
            port = 16'h0001;
         else if (p == 5)
            port = 16'hFFFF;
         else
            port = 16'($urandom_range(1, 65535));
         idle_gaps = (p % 3 != 1);
         set_keys(k[0], k[1], k[2], k[3], 3'(p), port);
         phase_end = items_sent + 30;
         while (items_sent < phase_end) begin
            t = $urandom_range(0, 99);
            if (t < 45) begin
               row = 16'($urandom);
               idx = 3'($urandom_range(0, 7));
               make_readable(idx);
               send_item(FUNC_SCAN, 3'($urandom_range(0, 7)), row, idx, 8'($urandom));
            end else if (t < 80) begin
               t = $urandom_range(0, 4);
               if (t == 4)
                  row = (port_key != 0 && $urandom_range(0, 3) != 0) ? port_key
                                                                     : 16'($urandom);
               else
                  row = {8'h00, key_octet[t]};
               send_item(FUNC_LOAD, 3'(t), row, 3'($urandom_range(0, 7)), dense_byte());
            end else begin
               sel = 3'($urandom_range(0, 7));
               row = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 255));
               send_item(FUNC_LOAD, sel, row, 3'($urandom_range(0, 7)), 8'($urandom));
            end
         end
      end
   endtask

   // result checker; the receiver cannot stall, so every strobe is a transfer
   always @(posedge clock) begin
      flow_hit_type want;
      if (!reset && rsp_strobe) begin
         if (expected_flows.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: flow %0d found %0b last %0b",
                        rsp_flow_number, rsp_found, rsp_last);
         end else begin
            want = expected_flows.pop_front();
            if (rsp_flow_number !== want.flow_number || rsp_found !== want.found ||
                rsp_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: flow %0d found %0b last %0b, want %0d %0b %0b",
                           rsp_flow_number, rsp_found, rsp_last,
                           want.flow_number, want.found, want.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      key_octet = '{default: 8'h00};
      octets_used = '0;
      port_key = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_open_match();
      test_corner_loads();
      test_saturated_octets();
      test_random_phases();
      wait_quiet();
      if (mismatch_count == 0 && expected_flows.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
